### sv/scaled_matvec_with_offset_defines.svh
// Assertion macros for the scaled matrix-vector block.
// Used by the port checker; depends on nothing.
`ifndef SCALED_MATVEC_WITH_OFFSET_DEFINES_SVH
`define SCALED_MATVEC_WITH_OFFSET_DEFINES_SVH

// same-cycle implication, off during reset
`define SMVO_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smvo assertion failed");

// next-cycle implication, off during reset
`define SMVO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smvo assertion failed");

// property checked in and out of reset
`define SMVO_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("smvo assertion failed");

`endif

### sv/smvo_pkg.sv
// Shared types and constants of the scaled matrix-vector block.
// No dependencies.
package smvo_pkg;

    typedef logic [1:0]         t_opcode;
    typedef logic [4:0]         t_idx;
    typedef logic signed [15:0] t_val;
    typedef logic signed [21:0] t_wx;
    typedef logic signed [31:0] t_res;

    localparam t_opcode OP_LOAD_X = 2'd0;
    localparam t_opcode OP_LOAD_Y = 2'd1;
    localparam t_opcode OP_MAT    = 2'd2;

    localparam int IDX_SPAN = 32;

    typedef enum logic [1:0] {
        KIND_X,
        KIND_Y,
        KIND_MAT
    } t_kind;

    // classified word passed from front to back
    typedef struct packed {
        t_kind kind;
        t_idx  row;
        t_idx  col;
        t_wx   data;
        logic  last;
    } t_word;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    localparam t_res Q16_MAX = 32'sh7FFF_FFFF;
    localparam t_res Q16_MIN = 32'sh8000_0000;

endpackage

### sv/smvo_if.sv
// Valid/ready channel interfaces for input and result words.
// Depends on smvo_pkg.
interface smvo_in_if;
    logic              valid;
    logic              ready;
    smvo_pkg::t_opcode opcode;
    smvo_pkg::t_idx    row;
    smvo_pkg::t_idx    col;
    smvo_pkg::t_val    value;

    modport source(output valid, opcode, row, col, value, input ready);
    modport sink(input valid, opcode, row, col, value, output ready);
endinterface

interface smvo_out_if;
    logic           valid;
    logic           ready;
    smvo_pkg::t_idx out_row;
    smvo_pkg::t_res out_value;
    logic           saturated;

    modport source(output valid, out_row, out_value, saturated, input ready);
    modport sink(input valid, out_row, out_value, saturated, output ready);
endinterface

### sv/scaled_matvec_with_offset.sv
// Top level of the scaled matrix-vector block with offset.
// Depends on smvo_pkg, smvo_if, smvo_front, smvo_queue, smvo_back.
//
//   channel  dir  handshake      word
//   i_in     in   valid/ready    opcode, row, col, value
//   o_out    out  valid/ready    out_row, out_value, saturated
//
// One word per cycle while the queue is not full; a row result reaches the
// output register after its last matrix word is accepted, through queue pop
// with store read, multiply, accumulate, offset add and saturate.
// i_in stalls only while the four-word queue is full; the back pipeline
// freezes as a whole while an untaken result sits in the output register.
// Reset clears valids, queue pointers and the row accumulator; x/y stores
// are not cleared.
module scaled_matvec_with_offset #(
    parameter int VEC_LEN = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    smvo_in_if.sink     i_in,
    smvo_out_if.source  o_out
);

    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    smvo_pkg::t_word front_word;
    smvo_pkg::t_word queue_word;

    smvo_front #(
        .VEC_LEN (VEC_LEN)
    ) u_front (
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_word  (front_word)
    );

    smvo_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (front_word),
        .i_pop   (pop),
        .o_word  (queue_word),
        .o_full  (full),
        .o_empty (empty)
    );

    smvo_back #(
        .VEC_LEN (VEC_LEN)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (queue_word),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

### sv/smvo_front.sv
// Front end: drops out-of-range and unknown-opcode words, weights x by col + 2.
// Depends on smvo_pkg and smvo_in_if.
module smvo_front #(
    parameter int VEC_LEN = 32
) (
    smvo_in_if.sink         i_in,
    input  logic            i_full,
    output logic            o_push,
    output smvo_pkg::t_word o_word
);

    logic            col_ok;
    logic            row_ok;
    logic            keep;
    smvo_pkg::t_wx   weighted;
    logic [7:0]      scale;

    assign col_ok = int'(i_in.col) < VEC_LEN;
    assign row_ok = int'(i_in.row) < VEC_LEN;
    assign scale  = {3'b000, i_in.col} + 8'd2;
    assign weighted = smvo_pkg::t_wx'(i_in.value) * smvo_pkg::t_wx'($signed(scale));

    always_comb begin
        keep        = 1'b0;
        o_word.kind = smvo_pkg::KIND_MAT;
        o_word.row  = i_in.row;
        o_word.col  = i_in.col;
        o_word.data = smvo_pkg::t_wx'(i_in.value);
        o_word.last = int'(i_in.col) == VEC_LEN - 1;
        case (i_in.opcode)
            smvo_pkg::OP_LOAD_X: begin
                keep        = col_ok;
                o_word.kind = smvo_pkg::KIND_X;
                o_word.data = weighted;
            end
            smvo_pkg::OP_LOAD_Y: begin
                keep        = row_ok;
                o_word.kind = smvo_pkg::KIND_Y;
            end
            smvo_pkg::OP_MAT: begin
                keep        = row_ok && col_ok;
            end
            default: begin
                keep        = 1'b0;
            end
        endcase
    end

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full && keep;

endmodule

### sv/smvo_queue.sv
// Short FIFO of classified words between front and back.
// Depends on smvo_pkg.
module smvo_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  smvo_pkg::t_word i_word,
    input  logic            i_pop,
    output smvo_pkg::t_word o_word,
    output logic            o_full,
    output logic            o_empty
);

    smvo_pkg::t_word              r_mem [smvo_pkg::QDEPTH];
    logic [smvo_pkg::QAW-1:0]     r_wptr;
    logic [smvo_pkg::QAW-1:0]     r_rptr;
    logic [smvo_pkg::QAW:0]       r_count;
    logic [smvo_pkg::QAW:0]       n_count;

    assign o_full  = r_count == (smvo_pkg::QAW + 1)'(smvo_pkg::QDEPTH);
    assign o_empty = r_count == '0;
    assign o_word  = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

### sv/smvo_back.sv
// Back end: x/y stores, multiply, row accumulator, offset and saturation.
// Depends on smvo_pkg and smvo_out_if.
module smvo_back #(
    parameter int VEC_LEN = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  smvo_pkg::t_word i_word,
    input  logic            i_empty,
    output logic            o_pop,
    smvo_out_if.source      o_out
);

    localparam int DEPTH = (VEC_LEN < smvo_pkg::IDX_SPAN) ? VEC_LEN : smvo_pkg::IDX_SPAN;
    localparam int AW    = $clog2(DEPTH);

    smvo_pkg::t_wx  r_wx_mem [DEPTH];
    smvo_pkg::t_val r_y_mem  [DEPTH];

    logic           en;

    // stage A: store read
    logic           r_a_valid;
    logic           r_a_last;
    smvo_pkg::t_idx r_a_row;
    smvo_pkg::t_val r_a_val;
    smvo_pkg::t_wx  r_rd_wx;
    smvo_pkg::t_val r_rd_y;

    // stage B: product
    logic                r_b_valid;
    logic                r_b_last;
    smvo_pkg::t_idx      r_b_row;
    smvo_pkg::t_val      r_b_y;
    logic signed [37:0]  r_b_prod;

    // stage C: accumulate
    logic signed [47:0]  r_acc;
    logic signed [47:0]  n_sum;
    logic                r_c_valid;
    smvo_pkg::t_idx      r_c_row;
    smvo_pkg::t_val      r_c_y;
    logic signed [47:0]  r_c_sum;

    // stage D: add y
    logic                r_d_valid;
    smvo_pkg::t_idx      r_d_row;
    logic signed [48:0]  r_d_sum;

    // output register
    logic                r_o_valid;
    smvo_pkg::t_idx      r_o_row;
    smvo_pkg::t_res      r_o_value;
    logic                r_o_sat;

    logic signed [48:0]  n_fin;
    logic                n_hi;
    logic                n_lo;

    assign en    = !r_o_valid || o_out.ready;
    assign o_pop = en && !i_empty;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            case (i_word.kind)
                smvo_pkg::KIND_X: r_wx_mem[i_word.col[AW-1:0]] <= i_word.data;
                smvo_pkg::KIND_Y: r_y_mem[i_word.row[AW-1:0]]  <= i_word.data[15:0];
                default: ;
            endcase
            r_rd_wx <= r_wx_mem[i_word.col[AW-1:0]];
            r_rd_y  <= r_y_mem[i_word.row[AW-1:0]];
        end
    end

    assign n_sum = r_acc + {{10{r_b_prod[37]}}, r_b_prod};

    always_comb begin
        n_fin = r_d_sum[48] ? r_d_sum : r_d_sum + 49'sd65536;
        n_hi  = !n_fin[48] && (|n_fin[47:31]);
        n_lo  = n_fin[48] && !(&n_fin[47:31]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_last <= i_word.last;
            r_a_row  <= i_word.row;
            r_a_val  <= i_word.data[15:0];
            r_b_last <= r_a_last;
            r_b_row  <= r_a_row;
            r_b_y    <= r_rd_y;
            r_b_prod <= 38'(r_rd_wx) * 38'(r_a_val);
            r_c_row  <= r_b_row;
            r_c_y    <= r_b_y;
            r_c_sum  <= n_sum;
            r_d_row  <= r_c_row;
            r_d_sum  <= {{25{r_c_y[15]}}, r_c_y, 8'h00} + {r_c_sum[47], r_c_sum};
            if (r_d_valid) begin
                r_o_row   <= r_d_row;
                r_o_sat   <= n_hi || n_lo;
                r_o_value <= n_hi ? smvo_pkg::Q16_MAX :
                             n_lo ? smvo_pkg::Q16_MIN : n_fin[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_acc     <= '0;
        end else if (en) begin
            r_a_valid <= o_pop && (i_word.kind == smvo_pkg::KIND_MAT);
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid && r_b_last;
            r_d_valid <= r_c_valid;
            r_o_valid <= r_d_valid;
            if (r_b_valid) begin
                r_acc <= r_b_last ? '0 : n_sum;
            end
        end
    end

    assign o_out.valid     = r_o_valid;
    assign o_out.out_row   = r_o_row;
    assign o_out.out_value = r_o_value;
    assign o_out.saturated = r_o_sat;

endmodule

### sv/smvo_checker.sv
// Port checker for the result channel, bound to the top level.
// Depends on smvo_pkg and scaled_matvec_with_offset_defines.svh.
`include "scaled_matvec_with_offset_defines.svh"

module smvo_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input smvo_pkg::t_idx i_out_row,
    input smvo_pkg::t_res i_out_value,
    input logic           i_out_sat
);

    logic        out_stall;
    logic [37:0] out_word;
    logic        out_clip;
    logic        out_at_rail;
    logic        out_pos_unsat;

    assign out_stall     = i_out_valid && !i_out_ready;
    assign out_word      = {i_out_row, i_out_value, i_out_sat};
    assign out_clip      = i_out_valid && i_out_sat;
    assign out_at_rail   = (i_out_value == smvo_pkg::Q16_MAX) ||
                           (i_out_value == smvo_pkg::Q16_MIN);
    assign out_pos_unsat = i_out_valid && !i_out_sat && !i_out_value[31];

    `SMVO_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid && $stable(out_word))
    `SMVO_ASSERT(a_sat_clip, i_clk, i_rst_n, out_clip, out_at_rail)
    `SMVO_ASSERT(a_plus_one, i_clk, i_rst_n, out_pos_unsat, |i_out_value[30:16])
    `SMVO_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind scaled_matvec_with_offset smvo_checker u_smvo_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_row   (o_out.out_row),
    .i_out_value (o_out.out_value),
    .i_out_sat   (o_out.saturated)
);

### tb/sv/tb.sv
// Self-checking testbench for scaled_matvec_with_offset: random and directed words
// are streamed in and each row result is compared against an in-bench predictor.
// Depends on smvo_pkg, smvo_if and the RTL of the block.
`timescale 1ns / 100ps

module tb;

    localparam int                VEC_LEN     = 32;
    localparam smvo_pkg::t_opcode OP_NONE     = 2'd3;
    localparam int                LONG_WORDS  = 96;
    localparam int                RAND_WORDS  = 1270;
    localparam int                MIN_ROWS    = 30;
    localparam int                HOLD_LEN    = 400;
    localparam int                IDLE_LIMIT  = 4000;
    localparam int                TAIL_CYCLES = 20;

    typedef struct {
        smvo_pkg::t_opcode op;
        smvo_pkg::t_idx    row;
        smvo_pkg::t_idx    col;
        smvo_pkg::t_val    value;
    } t_in_word;

    typedef struct {
        smvo_pkg::t_idx row;
        smvo_pkg::t_res value;
        logic           sat;
    } t_row_result;

    logic i_clk;
    logic i_rst_n;

    smvo_in_if  in_ch();
    smvo_out_if out_ch();

    scaled_matvec_with_offset #(.VEC_LEN(VEC_LEN)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_in_word    word_q[$];
    t_row_result row_results_q[$];

    smvo_pkg::t_wx  wx_store[VEC_LEN];
    smvo_pkg::t_val y_store[VEC_LEN];
    logic [47:0]    row_acc;

    int   words_total;
    int   words_taken;
    int   rows_planned;
    int   rand_words;
    int   results_seen;
    int   fail_count;
    int   idle_cycles;
    bit   in_took;
    bit   hold_on;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm = $urandom_range(30, 120);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic smvo_pkg::t_val rand_val();
        case ($urandom_range(0, 11))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return smvo_pkg::t_val'($urandom());
        endcase
    endfunction

    function automatic smvo_pkg::t_idx rand_idx();
        return smvo_pkg::t_idx'($urandom_range(0, VEC_LEN - 1));
    endfunction

    task automatic queue_word(smvo_pkg::t_opcode op, smvo_pkg::t_idx row,
                              smvo_pkg::t_idx col, smvo_pkg::t_val value);
        t_in_word w;
        w.op    = op;
        w.row   = row;
        w.col   = col;
        w.value = value;
        word_q.push_back(w);
        if (op == smvo_pkg::OP_MAT && col == smvo_pkg::t_idx'(VEC_LEN - 1)) rows_planned++;
        if (op != OP_NONE) rand_words++;
    endtask

    task automatic queue_row(smvo_pkg::t_idx row, int last_col);
        for (int c = 0; c <= last_col; c++) begin
            queue_word(smvo_pkg::OP_MAT, row, smvo_pkg::t_idx'(c), rand_val());
        end
    endtask

    // expected row results for one accepted word
    task automatic predict_word(t_in_word w);
        int          wxv;
        longint      prod;
        longint      r;
        t_row_result res;
        case (w.op)
            smvo_pkg::OP_LOAD_X: begin
                wxv = int'(w.value) * (int'(w.col) + 2);
                wx_store[w.col] = wxv[21:0];
            end
            smvo_pkg::OP_LOAD_Y: y_store[w.row] = w.value;
            smvo_pkg::OP_MAT: begin
                prod = longint'(wx_store[w.col]) * longint'(w.value);
                row_acc = row_acc + prod[47:0];
                if (w.col == smvo_pkg::t_idx'(VEC_LEN - 1)) begin
                    r = longint'(y_store[w.row]) * 256 + longint'($signed(row_acc));
                    if (r >= 0) r += 65536;
                    res.sat = 1'b0;
                    if (r > longint'(smvo_pkg::Q16_MAX)) begin
                        r = longint'(smvo_pkg::Q16_MAX);
                        res.sat = 1'b1;
                    end else if (r < longint'(smvo_pkg::Q16_MIN)) begin
                        r = longint'(smvo_pkg::Q16_MIN);
                        res.sat = 1'b1;
                    end
                    res.row   = w.row;
                    res.value = r[31:0];
                    row_results_q.push_back(res);
                    row_acc = '0;
                end
            end
            default: ;
        endcase
    endtask

    // monitor: accepted words, row results, idle watchdog
    always @(posedge i_clk) begin : monitor_proc
        t_in_word    w;
        t_row_result exp_res;
        bit          out_took;
        in_took  = 1'b0;
        out_took = 1'b0;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                in_took = 1'b1;
                words_taken++;
                w.op    = in_ch.opcode;
                w.row   = in_ch.row;
                w.col   = in_ch.col;
                w.value = in_ch.value;
                predict_word(w);
            end
            if (out_ch.valid && out_ch.ready) begin
                out_took = 1'b1;
                results_seen++;
                if (row_results_q.size() == 0) begin
                    $display("%0t: unexpected result, row %0d value %0d sat %0b", $time,
                             out_ch.out_row, out_ch.out_value, out_ch.saturated);
                    fail_count++;
                end else begin
                    exp_res = row_results_q.pop_front();
                    if (out_ch.out_row !== exp_res.row) begin
                        $display("%0t: out_row expected %0d actual %0d", $time,
                                 exp_res.row, out_ch.out_row);
                        fail_count++;
                    end
                    if (out_ch.out_value !== exp_res.value) begin
                        $display("%0t: out_value expected %0d actual %0d", $time,
                                 exp_res.value, out_ch.out_value);
                        fail_count++;
                    end
                    if (out_ch.saturated !== exp_res.sat) begin
                        $display("%0t: saturated expected %0b actual %0b", $time,
                                 exp_res.sat, out_ch.saturated);
                        fail_count++;
                    end
                end
            end
            if (in_took || out_took) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("** scaled_matvec_with_offset: FAILED **");
                $finish;
            end
        end
    end

    // input driver
    always @(negedge i_clk) begin : drive_proc
        t_in_word w;
        int       gap_left;
        int       tx_calm;
        bit       busy;
        if (i_rst_n) begin
            if (busy && in_took) busy = 1'b0;
            if (!busy) begin
                if (hold_on) gap_left = 0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (word_q.size() > 0) begin
                    w = word_q.pop_front();
                    in_ch.opcode <= w.op;
                    in_ch.row    <= w.row;
                    in_ch.col    <= w.col;
                    in_ch.value  <= w.value;
                    busy = 1'b1;
                    gap_left = pick_gap(tx_calm);
                end
            end
            in_ch.valid <= busy;
        end
    end

    // result receiver, with one long hold-off once results are flowing
    always @(negedge i_clk) begin : receive_proc
        int stall_left;
        int hold_left;
        int rx_calm;
        bit hold_done;
        bit rdy;
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (!hold_done && results_seen >= 3) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
                rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
                stall_left = ($urandom_range(0, 2) == 0) ? pick_gap(rx_calm) : 0;
            end
            out_ch.ready <= rdy;
            hold_on      <= (hold_left > 0);
        end
    end

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.opcode = smvo_pkg::OP_LOAD_X;
        in_ch.row    = '0;
        in_ch.col    = '0;
        in_ch.value  = '0;
        out_ch.ready = 1'b0;
        i_rst_n      = 1'b0;
        row_acc      = '0;

        // directed: extremes, every opcode, saturation both ways, offset rule
        queue_word(smvo_pkg::OP_LOAD_X, 5'd0,  5'd0,  16'sh8000);
        queue_word(smvo_pkg::OP_LOAD_X, 5'd0,  5'd1,  16'sh7FFF);
        queue_word(smvo_pkg::OP_LOAD_X, 5'd0,  5'd31, 16'sh8000);
        queue_word(smvo_pkg::OP_LOAD_X, 5'd0,  5'd30, 16'sh7FFF);
        queue_word(smvo_pkg::OP_LOAD_Y, 5'd0,  5'd0,  16'sh7FFF);
        queue_word(smvo_pkg::OP_LOAD_Y, 5'd5,  5'd0,  16'sh8000);
        queue_word(smvo_pkg::OP_LOAD_Y, 5'd31, 5'd0,  16'sh0000);
        queue_word(OP_NONE,             5'd31, 5'd31, 16'sh7FFF);
        queue_word(smvo_pkg::OP_MAT,    5'd0,  5'd0,  16'sh8000);
        queue_word(smvo_pkg::OP_MAT,    5'd0,  5'd31, 16'sh8000);
        queue_word(smvo_pkg::OP_MAT,    5'd7,  5'd1,  16'sh7FFF);
        queue_word(smvo_pkg::OP_MAT,    5'd5,  5'd31, 16'sh7FFF);
        queue_word(smvo_pkg::OP_MAT,    5'd31, 5'd31, 16'sh0000);
        queue_word(smvo_pkg::OP_MAT,    5'd5,  5'd31, 16'sh0000);
        queue_word(smvo_pkg::OP_LOAD_Y, 5'd31, 5'd0,  16'shFFFF);
        queue_word(smvo_pkg::OP_MAT,    5'd31, 5'd31, 16'sh0000);
        queue_word(smvo_pkg::OP_MAT,    5'd30, 5'd30, 16'sh8000);
        queue_word(smvo_pkg::OP_MAT,    5'd31, 5'd31, 16'sh7FFF);
        queue_word(OP_NONE,             5'd0,  5'd0,  16'sh8000);

        // long row, sum far past the 32-bit range
        queue_word(smvo_pkg::OP_LOAD_X, 5'd0, 5'd30, 16'sh8000);
        queue_word(smvo_pkg::OP_LOAD_Y, 5'd1, 5'd0,  16'sh0000);
        for (int i = 0; i < LONG_WORDS; i++) begin
            queue_word(smvo_pkg::OP_MAT, 5'd1, 5'd30, 16'sh8000);
        end
        queue_word(smvo_pkg::OP_MAT, 5'd1, 5'd31, 16'sh0000);

        // random: full vector load, then mostly complete rows
        rand_words = 0;
        for (int i = 0; i < VEC_LEN; i++) begin
            queue_word(smvo_pkg::OP_LOAD_X, rand_idx(), smvo_pkg::t_idx'(i), rand_val());
            queue_word(smvo_pkg::OP_LOAD_Y, smvo_pkg::t_idx'(i), rand_idx(), rand_val());
        end
        while (rand_words < RAND_WORDS || rows_planned < MIN_ROWS) begin
            case ($urandom_range(0, 19))
                0, 1: queue_word(OP_NONE, rand_idx(), rand_idx(), rand_val());
                2, 3: queue_word(smvo_pkg::OP_MAT, rand_idx(), rand_idx(), rand_val());
                4, 5: queue_row(rand_idx(), $urandom_range(0, VEC_LEN - 2));
                default: begin
                    repeat ($urandom_range(0, 4)) begin
                        if ($urandom_range(0, 1) == 0)
                            queue_word(smvo_pkg::OP_LOAD_X, rand_idx(), rand_idx(), rand_val());
                        else
                            queue_word(smvo_pkg::OP_LOAD_Y, rand_idx(), rand_idx(), rand_val());
                    end
                    queue_row(rand_idx(), VEC_LEN - 1);
                end
            endcase
        end
        words_total = word_q.size();

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        while (words_taken < words_total || row_results_q.size() > 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("** scaled_matvec_with_offset: PASSED **");
        end else begin
            $display("** scaled_matvec_with_offset: FAILED **");
        end
        $finish;
    end

endmodule
